/* hdl/spatial_hash_point_dedup_core_defines.svh */
// assertion macros for the spatial hash point dedup core
`ifndef SPATIAL_HASH_POINT_DEDUP_CORE_DEFINES_SVH
`define SPATIAL_HASH_POINT_DEDUP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// implication in the same cycle, ignored during reset
`define SPHD_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// implication checked in the next cycle, ignored during reset
`define SPHD_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// implication checked in the next cycle, checked through reset too
`define SPHD_ASSERT_NXT_RST(lbl, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define SPHD_ASSERT_IMP(lbl, a, b)
`define SPHD_ASSERT_NXT(lbl, a, b)
`define SPHD_ASSERT_NXT_RST(lbl, a, b)
`endif
`endif

/* hdl/sphd_pkg.sv */
// types and constants shared by the point dedup core
`timescale 1ns / 1ps
package sphd_pkg;
  localparam logic [31:0] PRIME_X    = 32'd73856093;
  localparam logic [31:0] PRIME_Y    = 32'd19349663;
  localparam logic [31:0] PRIME_Z    = 32'd83492791;
  localparam int          QUANT_FRAC = 28;
  localparam logic [31:0] QUANT_OFS  = 32'd50000;
  localparam logic [31:0] TOL_RESET  = 32'd720;
  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;
  localparam logic [40:0] AXIS_LIM   = 41'd65536;

  localparam logic [1:0] STAT_MATCH = 2'd0;
  localparam logic [1:0] STAT_NEW   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [15:0] site_id;
    logic [1:0]  status;
    logic [16:0] site_count;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_QUANT, S_HASH, S_HEAD, S_HWAIT,
    S_LOOK, S_SQ, S_CMP, S_INSERT, S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic quant;
    logic hash;
    logic head_rd;
    logic head_take;
    logic fetch;
    logic square;
    logic advance;
    logic set_match;
    logic set_full;
    logic insert;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic walk_end;
    logic full;
    logic match;
    logic out_free;
  } stat_t;
endpackage

/* hdl/sphd_ctrl.sv */
// sequencer for bucket clearing, hashing and chain walking
`timescale 1ns / 1ps
module sphd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sphd_pkg::stat_t stat,
  output sphd_pkg::cmd_t  cmd
);
  import sphd_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (stat.clear_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_QUANT;
      S_QUANT:  state_nxt = S_HASH;
      S_HASH:   state_nxt = S_HEAD;
      S_HEAD:   state_nxt = S_HWAIT;
      S_HWAIT:  state_nxt = S_LOOK;
      S_LOOK: begin
        if (!stat.walk_end) state_nxt = S_SQ;
        else if (stat.full) state_nxt = S_DONE;
        else state_nxt = S_INSERT;
      end
      S_SQ:     state_nxt = S_CMP;
      S_CMP:    state_nxt = stat.match ? S_DONE : S_LOOK;
      S_INSERT: state_nxt = S_DONE;
      S_DONE:   if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR:  cmd.clear = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_QUANT:  cmd.quant = 1'b1;
      S_HASH:   cmd.hash = 1'b1;
      S_HEAD:   cmd.head_rd = 1'b1;
      S_HWAIT:  cmd.head_take = 1'b1;
      S_LOOK: begin
        cmd.fetch = !stat.walk_end;
        cmd.set_full = stat.walk_end && stat.full;
      end
      S_SQ:     cmd.square = 1'b1;
      S_CMP: begin
        cmd.set_match = stat.match;
        cmd.advance = !stat.match;
      end
      S_INSERT: cmd.insert = 1'b1;
      S_DONE:   cmd.out_load = stat.out_free;
      default:  cmd = '0;
    endcase
  end
endmodule

/* hdl/sphd_datapath.sv */
// hashing, bucket and entry memories, distance test and result register
`timescale 1ns / 1ps
module sphd_datapath #(
  parameter int CAPACITY    = 65536,
  parameter int BUCKET_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sphd_pkg::in_t  in_data,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  input  sphd_pkg::cmd_t cmd,
  output sphd_pkg::stat_t stat,
  input  logic           out_ready,
  output logic           out_valid,
  output sphd_pkg::out_t out_data
);
  import sphd_pkg::*;

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NB = 1 << BUCKET_BITS;

  logic [PW-1:0] bucket_mem [NB];
  logic [PW-1:0] link_mem [CAPACITY];
  logic signed [39:0] mx_mem [CAPACITY];
  logic signed [39:0] my_mem [CAPACITY];
  logic signed [39:0] mz_mem [CAPACITY];

  logic [31:0] tol_r;
  logic [BUCKET_BITS-1:0] clr_r;
  logic [PW-1:0] count_r, cur_r, steps_r, head_q, link_q, head_r, res_id_r;
  logic [1:0] res_stat_r;
  logic [16:0] res_count_r;
  logic signed [39:0] px_r, py_r, pz_r, sx_q, sy_q, sz_q;
  logic [31:0] qx_r, qy_r, qz_r, hx_r, hy_r, hz_r;
  logic [BUCKET_BITS-1:0] bucket_r, bucket_addr;
  logic [31:0] sqx_r, sqy_r, sqz_r;
  logic out_valid_r;
  out_t out_r;

  // quantise: floor(c * 100) + 50000 mod 2^32
  function automatic logic [31:0] quant(input logic signed [39:0] c);
    logic signed [46:0] p;
    logic signed [46:0] f;
    p = 47'(c) * 47'sd100;
    f = p >>> QUANT_FRAC;
    return f[31:0] + QUANT_OFS;
  endfunction

  // saturating square of one axis difference
  function automatic logic [31:0] axis_sq(input logic signed [39:0] a,
                                          input logic signed [39:0] b);
    logic signed [40:0] d;
    logic [40:0] m;
    d = 41'(a) - 41'(b);
    m = d[40] ? 41'(-d) : 41'(d);
    if (m >= AXIS_LIM) return SAT32;
    return 32'(m[15:0]) * 32'(m[15:0]);
  endfunction

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // input capture, quantise and hash pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_data.pos_x;
      py_r <= in_data.pos_y;
      pz_r <= in_data.pos_z;
    end
    if (cmd.quant) begin
      qx_r <= quant(px_r);
      qy_r <= quant(py_r);
      qz_r <= quant(pz_r);
    end
    if (cmd.hash) begin
      hx_r <= qx_r * PRIME_X;
      hy_r <= qy_r * PRIME_Y;
      hz_r <= qz_r * PRIME_Z;
    end
    if (cmd.head_rd) bucket_r <= bucket_addr;
  end

  assign bucket_addr = BUCKET_BITS'(hx_r ^ hy_r ^ hz_r);

  // bucket head memory
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      bucket_mem[clr_r] <= '0;
    end else if (cmd.insert) begin
      bucket_mem[bucket_r] <= count_r + 1'b1;
    end
    if (cmd.head_rd) head_q <= bucket_mem[bucket_addr];
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      link_mem[count_r[AW-1:0]] <= head_r;
      mx_mem[count_r[AW-1:0]] <= px_r;
      my_mem[count_r[AW-1:0]] <= py_r;
      mz_mem[count_r[AW-1:0]] <= pz_r;
    end
    if (cmd.fetch) begin
      link_q <= link_mem[cur_r[AW-1:0] - 1'b1];
      sx_q <= mx_mem[cur_r[AW-1:0] - 1'b1];
      sy_q <= my_mem[cur_r[AW-1:0] - 1'b1];
      sz_q <= mz_mem[cur_r[AW-1:0] - 1'b1];
    end
  end

  // chain walk registers
  always_ff @(posedge clk) begin
    if (cmd.head_take) begin
      head_r <= head_q;
      cur_r <= head_q;
      steps_r <= '0;
    end else if (cmd.advance) begin
      cur_r <= link_q;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.square) begin
      sqx_r <= axis_sq(px_r, sx_q);
      sqy_r <= axis_sq(py_r, sy_q);
      sqz_r <= axis_sq(pz_r, sz_q);
    end
  end

  // point count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.insert) begin
      count_r <= count_r + 1'b1;
    end
  end

  // distance sum and compare
  logic [33:0] dsum;
  logic [31:0] dsat;
  assign dsum = 34'(sqx_r) + 34'(sqy_r) + 34'(sqz_r);
  assign dsat = (dsum > 34'(SAT32)) ? SAT32 : dsum[31:0];

  // status to the sequencer
  always_comb begin
    stat.clear_last = (clr_r == BUCKET_BITS'(NB - 1));
    stat.walk_end = (cur_r == '0) || (cur_r > PW'(CAPACITY)) || (steps_r >= count_r);
    stat.full = (count_r >= PW'(CAPACITY));
    stat.match = (dsat < tol_r);
    stat.out_free = !out_valid_r || out_ready;
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.set_match) begin
      res_id_r <= cur_r - 1'b1;
      res_stat_r <= STAT_MATCH;
      res_count_r <= 17'(count_r);
    end else if (cmd.set_full) begin
      res_id_r <= '0;
      res_stat_r <= STAT_FULL;
      res_count_r <= 17'(count_r);
    end else if (cmd.insert) begin
      res_id_r <= count_r;
      res_stat_r <= STAT_NEW;
      res_count_r <= 17'(count_r + 1'b1);
    end
  end

  // output register
  logic [31:0] id_ext;
  assign id_ext = 32'(res_id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.site_id <= id_ext[15:0];
      out_r.status <= res_stat_r;
      out_r.site_count <= res_count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule

/* hdl/spatial_hash_point_dedup_core.sv */
// spatial hash point dedup core: each point is quantised and hashed, its bucket head read
// and the chain walked to a match; at the chain end it is inserted unless the table is full
// one point at a time: the next transfer is taken the cycle after the result is loaded,
// so while the output register is held, the result is not loaded and no transfer is taken
// rst_n sync active low: count zeroed, tolerance 720, then a clearing pass over all
// 2^BUCKET_BITS buckets empties the bucket memory before the first transfer is taken
`timescale 1ns / 1ps
`include "spatial_hash_point_dedup_core_defines.svh"
module spatial_hash_point_dedup_core #(
  parameter int CAPACITY    = 65536,
  parameter int BUCKET_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sphd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sphd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata
);
  import sphd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  sphd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  // datapath
  sphd_datapath #(.CAPACITY(CAPACITY), .BUCKET_BITS(BUCKET_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .cmd(cmd), .stat(stat), .out_ready(out_ready),
    .out_valid(out_valid), .out_data(out_data)
  );

  // checks
  `SPHD_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `SPHD_ASSERT_IMP(a_full_id_zero, out_valid && out_data.status == STAT_FULL,
                   out_data.site_id == 16'd0)
  `SPHD_ASSERT_NXT_RST(a_reset_no_out, !rst_n, !out_valid && !in_ready)
endmodule
